>>> rtl/core/msfq_pkg.sv
// ----------------------------------------------------------------------------
// Moisture sensor fault qualifier package
// Widths, reset values, register indexes and sequencer states shared by the
// qualifier RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package msfq_pkg;

   localparam int SAMPLE_WIDTH        = 16;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int LEVEL_WIDTH         = 15;
   localparam int RUN_WIDTH           = 8;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 16;

   localparam logic [LEVEL_WIDTH-1:0] FULL_SCALE = 15'd25600;
   localparam logic [RUN_WIDTH-1:0]   RUN_MAX    = 8'd255;

   localparam logic [SAMPLE_WIDTH-1:0] DRY_READING_RESET     = 16'd20000;
   localparam logic [SAMPLE_WIDTH-1:0] WET_READING_RESET     = 16'd9000;
   localparam logic [LEVEL_WIDTH-1:0]  STUCK_TOLERANCE_RESET = 15'd26;
   localparam logic [RUN_WIDTH-1:0]    STUCK_LIMIT_RESET     = 8'd10;
   localparam logic [RUN_WIDTH-1:0]    CLEAR_LIMIT_RESET     = 8'd3;
   localparam logic [LEVEL_WIDTH-1:0]  DRY_THRESHOLD_RESET   = 15'd7680;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRY_READING     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WET_READING     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STUCK_TOLERANCE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STUCK_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLEAR_LIMIT     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRY_THRESHOLD   = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MULT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage : msfq_pkg

`default_nettype wire

>>> rtl/core/moisture_sensor_fault_qualifier.sv
// ----------------------------------------------------------------------------
// Moisture sensor fault qualifier
// Scales a converter sample to percent with a bit-serial restoring divider,
// tracks stuck readings and latches a sensor fault.
//
//   Channel | Direction | Handshake            | Content
//   req     | in        | req_valid/req_ready  | raw sample, read-succeeded flag
//   rsp     | out       | rsp_valid/rsp_ready  | level, fault, dry, last raw
//   csr     | in        | csr_valid/csr_ready  | register index, write data
//
// A good sample passes through operand set-up, the scaling multiply, the
// bit-serial divider and the load of the result register. A zero span, a
// reading equal to the dry point, opposite signs or a saturated reading skip
// the divider. A failed read goes straight to the result register. A new
// transaction is accepted only once the sequencer is back in idle, so samples
// are not overlapped. Synchronous active-high reset restores the register
// defaults and clears the sequencer, the response valid and the stuck and
// fault state. A stalled result holds the sequencer in its final state until
// the output register is free; req_ready is high only in the idle state.
// ----------------------------------------------------------------------------
`default_nettype none

module moisture_sensor_fault_qualifier
   import msfq_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    req_raw_sample,
   input  wire logic                              req_sample_valid,

   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic        [LEVEL_WIDTH-1:0]     rsp_moisture_level,
   output      logic                              rsp_fault_flag,
   output      logic                              rsp_is_dry,
   output      logic signed [SAMPLE_WIDTH-1:0]    rsp_last_raw,

   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic        [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int EXT_SHIFT  = SAMPLE_WIDTH - SAMPLE_BITS;
   localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * SAMPLE_WIDTH;
   localparam int DIV_STEPS  = LEVEL_WIDTH;
   localparam int CNT_WIDTH  = $clog2(DIV_STEPS);

   state_type state_ff, state_in;

   logic [SAMPLE_WIDTH-1:0] dry_reading_ff;
   logic [SAMPLE_WIDTH-1:0] wet_reading_ff;
   logic [LEVEL_WIDTH-1:0]  stuck_tolerance_ff;
   logic [RUN_WIDTH-1:0]    stuck_limit_ff;
   logic [RUN_WIDTH-1:0]    clear_limit_ff;
   logic [LEVEL_WIDTH-1:0]  dry_threshold_ff;

   logic signed [SAMPLE_WIDTH-1:0] raw_ff;
   logic                           good_ff;
   logic [SAMPLE_WIDTH-1:0]        an_ff, an_in;
   logic [SAMPLE_WIDTH-1:0]        ad_ff, ad_in;
   logic                           zero_ff, zero_in;
   logic [SAMPLE_WIDTH-1:0]        rem_ff, rem_in;
   logic [LEVEL_WIDTH-1:0]         num_ff, num_in;
   logic [LEVEL_WIDTH-1:0]         quot_ff, quot_in;
   logic [CNT_WIDTH-1:0]           count_ff, count_in;

   logic [LEVEL_WIDTH-1:0]  previous_reading_ff, previous_reading_in;
   logic [RUN_WIDTH-1:0]    unchanged_run_ff, unchanged_run_in;
   logic [RUN_WIDTH-1:0]    recovery_run_ff, recovery_run_in;
   logic                    fault_latch_ff, fault_latch_in;
   logic [LEVEL_WIDTH-1:0]  accepted_level_ff, accepted_level_in;
   logic signed [SAMPLE_WIDTH-1:0] stored_raw_ff, stored_raw_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0]         rsp_level_ff;
   logic                           rsp_fault_ff;
   logic                           rsp_dry_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_raw_ff;

   logic req_take;
   logic commit;
   logic saturate;

   logic signed [SAMPLE_WIDTH-1:0] raw_shift;
   logic signed [SAMPLE_WIDTH-1:0] raw_ext;
   logic signed [DIFF_WIDTH-1:0]   num_diff;
   logic signed [DIFF_WIDTH-1:0]   den_diff;
   logic        [PROD_WIDTH-1:0]   product;
   logic        [DIFF_WIDTH-1:0]   trial;
   logic                           trial_ge;

   logic [LEVEL_WIDTH-1:0] step_diff;
   logic [RUN_WIDTH-1:0]   run_next;
   logic [RUN_WIDTH-1:0]   rec_next;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_reading_ff     <= DRY_READING_RESET;
         wet_reading_ff     <= WET_READING_RESET;
         stuck_tolerance_ff <= STUCK_TOLERANCE_RESET;
         stuck_limit_ff     <= STUCK_LIMIT_RESET;
         clear_limit_ff     <= CLEAR_LIMIT_RESET;
         dry_threshold_ff   <= DRY_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DRY_READING:     dry_reading_ff     <= csr_data;
            CSR_WET_READING:     wet_reading_ff     <= csr_data;
            CSR_STUCK_TOLERANCE: stuck_tolerance_ff <= csr_data[LEVEL_WIDTH-1:0];
            CSR_STUCK_LIMIT:     stuck_limit_ff     <= csr_data[RUN_WIDTH-1:0];
            CSR_CLEAR_LIMIT:     clear_limit_ff     <= csr_data[RUN_WIDTH-1:0];
            CSR_DRY_THRESHOLD:   dry_threshold_ff   <= csr_data[LEVEL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_sample_valid ? ST_PREP : ST_FINISH;
            end
         end
         ST_PREP:   state_in = ST_MULT;
         ST_MULT:   state_in = (zero_ff || saturate) ? ST_FINISH : ST_DIVIDE;
         ST_DIVIDE: state_in = (count_ff == '0) ? ST_FINISH : ST_DIVIDE;
         ST_FINISH: state_in = commit ? ST_IDLE : ST_FINISH;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_FINISH: commit    = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign req_take = req_valid && req_ready;

   // Operand set-up, scaling multiply and restoring divider.
   assign raw_shift = req_raw_sample <<< EXT_SHIFT;
   assign raw_ext   = raw_shift >>> EXT_SHIFT;

   assign num_diff = DIFF_WIDTH'($signed(dry_reading_ff)) - DIFF_WIDTH'(raw_ff);
   assign den_diff = DIFF_WIDTH'($signed(dry_reading_ff))
                   - DIFF_WIDTH'($signed(wet_reading_ff));
   assign an_in    = num_diff[DIFF_WIDTH-1] ? SAMPLE_WIDTH'(-num_diff)
                                            : num_diff[SAMPLE_WIDTH-1:0];
   assign ad_in    = den_diff[DIFF_WIDTH-1] ? SAMPLE_WIDTH'(-den_diff)
                                            : den_diff[SAMPLE_WIDTH-1:0];
   assign zero_in  = (num_diff == '0) || (den_diff == '0)
                  || (num_diff[DIFF_WIDTH-1] != den_diff[DIFF_WIDTH-1]);

   assign saturate = an_ff >= ad_ff;
   assign product  = PROD_WIDTH'(an_ff) * PROD_WIDTH'(FULL_SCALE);

   assign trial    = {rem_ff, num_ff[LEVEL_WIDTH-1]};
   assign trial_ge = trial >= DIFF_WIDTH'(ad_ff);

   always_comb begin
      rem_in   = rem_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      case (state_ff)
         ST_MULT: begin
            rem_in   = product[LEVEL_WIDTH +: SAMPLE_WIDTH];
            num_in   = product[LEVEL_WIDTH-1:0];
            count_in = CNT_WIDTH'(DIV_STEPS - 1);
            if (zero_ff) begin
               quot_in = '0;
            end else if (saturate) begin
               quot_in = FULL_SCALE;
            end
         end
         ST_DIVIDE: begin
            rem_in   = trial_ge ? SAMPLE_WIDTH'(trial - DIFF_WIDTH'(ad_ff))
                                : trial[SAMPLE_WIDTH-1:0];
            num_in   = {num_ff[LEVEL_WIDTH-2:0], 1'b0};
            quot_in  = {quot_ff[LEVEL_WIDTH-2:0], trial_ge};
            count_in = count_ff - 1'b1;
         end
         default: ;
      endcase
   end

   // Stuck detection and fault latch, applied when the result is committed.
   always_comb begin
      step_diff = (quot_ff > previous_reading_ff) ? quot_ff - previous_reading_ff
                                                  : previous_reading_ff - quot_ff;
      if (step_diff < stuck_tolerance_ff) begin
         run_next = (unchanged_run_ff == RUN_MAX) ? RUN_MAX : unchanged_run_ff + 1'b1;
      end else begin
         run_next = '0;
      end
      rec_next = (recovery_run_ff == RUN_MAX) ? RUN_MAX : recovery_run_ff + 1'b1;

      previous_reading_in = previous_reading_ff;
      unchanged_run_in    = unchanged_run_ff;
      recovery_run_in     = recovery_run_ff;
      fault_latch_in      = fault_latch_ff;
      accepted_level_in   = accepted_level_ff;
      stored_raw_in       = stored_raw_ff;

      if (good_ff) begin
         previous_reading_in = quot_ff;
         unchanged_run_in    = run_next;
         stored_raw_in       = raw_ff;
         if (run_next >= stuck_limit_ff) begin
            recovery_run_in = '0;
            fault_latch_in  = 1'b1;
         end else if (fault_latch_ff) begin
            if (rec_next >= clear_limit_ff) begin
               fault_latch_in    = 1'b0;
               recovery_run_in   = '0;
               accepted_level_in = quot_ff;
            end else begin
               recovery_run_in = rec_next;
            end
         end else begin
            recovery_run_in   = '0;
            accepted_level_in = quot_ff;
         end
      end
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         rsp_valid_ff        <= 1'b0;
         previous_reading_ff <= '0;
         unchanged_run_ff    <= '0;
         recovery_run_ff     <= '0;
         fault_latch_ff      <= 1'b0;
         accepted_level_ff   <= '0;
         stored_raw_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            previous_reading_ff <= previous_reading_in;
            unchanged_run_ff    <= unchanged_run_in;
            recovery_run_ff     <= recovery_run_in;
            fault_latch_ff      <= fault_latch_in;
            accepted_level_ff   <= accepted_level_in;
            stored_raw_ff       <= stored_raw_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff  <= raw_ext;
         good_ff <= req_sample_valid;
      end
      if (state_ff == ST_PREP) begin
         an_ff   <= an_in;
         ad_ff   <= ad_in;
         zero_ff <= zero_in;
      end
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      quot_ff  <= quot_in;
      count_ff <= count_in;
      if (commit) begin
         rsp_level_ff <= accepted_level_in;
         rsp_fault_ff <= fault_latch_in;
         rsp_dry_ff   <= !fault_latch_in && (accepted_level_in < dry_threshold_ff);
         rsp_raw_ff   <= stored_raw_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_moisture_level = rsp_level_ff;
   assign rsp_fault_flag     = rsp_fault_ff;
   assign rsp_is_dry         = rsp_dry_ff;
   assign rsp_last_raw       = rsp_raw_ff;

   // The partial remainder stays below the divisor throughout the division.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < ad_ff)
      else $error("divider remainder not below divisor");

   // The accepted level never exceeds full scale.
   assert property (@(posedge clock) disable iff (reset)
      accepted_level_ff <= FULL_SCALE)
      else $error("accepted level above full scale");

   // A faulty sensor is never reported as dry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fault_ff |-> !rsp_dry_ff)
      else $error("dry reported while fault set");

   // The fault is raised only by a run that meets the stuck limit.
   assert property (@(posedge clock) disable iff (reset)
      $rose(fault_latch_ff) |-> unchanged_run_ff >= stuck_limit_ff)
      else $error("fault raised without a stuck run");

endmodule : moisture_sensor_fault_qualifier

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Moisture sensor fault qualifier testbench
// Drives converter samples, some of them failed reads, through the request
// channel and predicts every response from a behavioural model of the scaling,
// stuck detection and fault latch. Results are compared field by field in
// order. The block is reconfigured between phases once it has drained, with
// calibration extremes, zero span, zero tolerance and the run limits at both
// ends. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import msfq_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] raw;
      logic                           ok;
   } sensor_read_t;

   typedef struct {
      logic        [LEVEL_WIDTH-1:0]  level;
      logic                           fault;
      logic                           dry;
      logic signed [SAMPLE_WIDTH-1:0] raw;
   } moisture_report_t;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [SAMPLE_WIDTH-1:0]    req_raw_sample = '0;
   logic                              req_sample_valid = 1'b0;

   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic        [LEVEL_WIDTH-1:0]     rsp_moisture_level;
   logic                              rsp_fault_flag;
   logic                              rsp_is_dry;
   logic signed [SAMPLE_WIDTH-1:0]    rsp_last_raw;

   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic        [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic        [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   logic signed [SAMPLE_WIDTH-1:0]    cfg_dry = DRY_READING_RESET;
   logic signed [SAMPLE_WIDTH-1:0]    cfg_wet = WET_READING_RESET;
   logic        [LEVEL_WIDTH-1:0]     cfg_tolerance = STUCK_TOLERANCE_RESET;
   logic        [RUN_WIDTH-1:0]       cfg_stuck_limit = STUCK_LIMIT_RESET;
   logic        [RUN_WIDTH-1:0]       cfg_clear_limit = CLEAR_LIMIT_RESET;
   logic        [LEVEL_WIDTH-1:0]     cfg_threshold = DRY_THRESHOLD_RESET;

   logic        [LEVEL_WIDTH-1:0]     last_level = '0;
   logic        [RUN_WIDTH-1:0]       unchanged_count = '0;
   logic        [RUN_WIDTH-1:0]       recovery_count = '0;
   logic                              fault_latched = 1'b0;
   logic        [LEVEL_WIDTH-1:0]     held_level = '0;
   logic signed [SAMPLE_WIDTH-1:0]    held_raw = '0;

   sensor_read_t                      sample_backlog[$];
   moisture_report_t                  pending_reports[$];
   sensor_read_t                      next_read;
   sensor_read_t                      seen_read;
   moisture_report_t                  predicted;
   moisture_report_t                  wanted;

   logic                              req_taken = 1'b0;
   logic                              rsp_taken = 1'b0;
   logic                              steady = 1'b0;
   int                                send_wait = 0;
   int                                hold_wait = 0;
   int                                quiet_cycles = 0;
   int                                mismatch_count = 0;

   moisture_sensor_fault_qualifier u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_raw_sample     (req_raw_sample),
      .req_sample_valid   (req_sample_valid),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_moisture_level (rsp_moisture_level),
      .rsp_fault_flag     (rsp_fault_flag),
      .rsp_is_dry         (rsp_is_dry),
      .rsp_last_raw       (rsp_last_raw),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pause_draw();
      if (steady) return 0;
      return int'($urandom_range(0, 3));
   endfunction

   function automatic logic [LEVEL_WIDTH-1:0] percent_of(
      input logic signed [SAMPLE_WIDTH-1:0] raw);
      int     num;
      int     den;
      longint quotient;
      num = int'(cfg_dry) - int'(raw);
      den = int'(cfg_dry) - int'(cfg_wet);
      if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return '0;
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      quotient = (longint'(num) * longint'(FULL_SCALE)) / longint'(den);
      if (quotient > longint'(FULL_SCALE)) quotient = longint'(FULL_SCALE);
      return LEVEL_WIDTH'(quotient);
   endfunction

   task automatic qualify_reading(input sensor_read_t rd, output moisture_report_t rep);
      logic [LEVEL_WIDTH-1:0] level;
      logic [LEVEL_WIDTH-1:0] delta;
      if (rd.ok) begin
         held_raw = rd.raw;
         level = percent_of(rd.raw);
         delta = (level > last_level) ? level - last_level : last_level - level;
         if (delta < cfg_tolerance) begin
            if (unchanged_count != RUN_MAX) unchanged_count = unchanged_count + 1'b1;
         end else begin
            unchanged_count = '0;
         end
         last_level = level;
         if (unchanged_count >= cfg_stuck_limit) begin
            recovery_count = '0;
            fault_latched = 1'b1;
         end else if (fault_latched) begin
            if (recovery_count != RUN_MAX) recovery_count = recovery_count + 1'b1;
            if (recovery_count >= cfg_clear_limit) begin
               fault_latched = 1'b0;
               recovery_count = '0;
               held_level = level;
            end
         end else begin
            recovery_count = '0;
            held_level = level;
         end
      end
      rep.level = held_level;
      rep.fault = fault_latched;
      rep.dry = !fault_latched && (held_level < cfg_threshold);
      rep.raw = held_raw;
   endtask

   // Requests and responses are sampled together so that a response is always
   // matched before the request of the same edge is predicted.
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      rsp_taken <= rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: response transaction with no expectation waiting: level %0d",
                        $time, rsp_moisture_level);
               mismatch_count++;
            end else begin
               wanted = pending_reports.pop_front();
               if (rsp_moisture_level !== wanted.level) begin
                  $display("%0t: moisture_level mismatch: expected %0d, actual %0d",
                           $time, wanted.level, rsp_moisture_level);
                  mismatch_count++;
               end
               if (rsp_fault_flag !== wanted.fault) begin
                  $display("%0t: fault_flag mismatch: expected %0d, actual %0d",
                           $time, wanted.fault, rsp_fault_flag);
                  mismatch_count++;
               end
               if (rsp_is_dry !== wanted.dry) begin
                  $display("%0t: is_dry mismatch: expected %0d, actual %0d",
                           $time, wanted.dry, rsp_is_dry);
                  mismatch_count++;
               end
               if (rsp_last_raw !== wanted.raw) begin
                  $display("%0t: last_raw mismatch: expected %0d, actual %0d",
                           $time, wanted.raw, rsp_last_raw);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            seen_read.raw = req_raw_sample;
            seen_read.ok = req_sample_valid;
            qualify_reading(seen_read, predicted);
            pending_reports.push_back(predicted);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = pause_draw();
      end else if (!req_valid || req_taken) begin
         if (send_wait > 0) begin
            send_wait = send_wait - 1;
            req_valid <= 1'b0;
         end else if (sample_backlog.size() > 0) begin
            next_read = sample_backlog.pop_front();
            req_raw_sample <= next_read.raw;
            req_sample_valid <= next_read.ok;
            req_valid <= 1'b1;
            send_wait = pause_draw();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_wait = pause_draw();
      end else begin
         if (rsp_taken) hold_wait = pause_draw();
         if (rsp_valid && hold_wait > 0) begin
            hold_wait = hold_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (hold_wait == 0);
         end
      end
   end

   task automatic push_read(input logic signed [SAMPLE_WIDTH-1:0] raw, input logic ok);
      sensor_read_t rd;
      rd.raw = raw;
      rd.ok = ok;
      sample_backlog.push_back(rd);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (sample_backlog.size() != 0 || req_valid || pending_reports.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0]  value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (index)
         CSR_DRY_READING:     cfg_dry = value;
         CSR_WET_READING:     cfg_wet = value;
         CSR_STUCK_TOLERANCE: cfg_tolerance = value[LEVEL_WIDTH-1:0];
         CSR_STUCK_LIMIT:     cfg_stuck_limit = value[RUN_WIDTH-1:0];
         CSR_CLEAR_LIMIT:     cfg_clear_limit = value[RUN_WIDTH-1:0];
         CSR_DRY_THRESHOLD:   cfg_threshold = value[LEVEL_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_DATA_WIDTH-1:0] dry, wet, tolerance,
                                 input logic [CSR_DATA_WIDTH-1:0] stuck, clear, threshold);
      write_register(CSR_DRY_READING, dry);
      write_register(CSR_WET_READING, wet);
      write_register(CSR_STUCK_TOLERANCE, tolerance);
      write_register(CSR_STUCK_LIMIT, stuck);
      write_register(CSR_CLEAR_LIMIT, clear);
      write_register(CSR_DRY_THRESHOLD, threshold);
   endtask

   // Mostly a sample between the calibration points, sometimes anywhere.
   function automatic int span_pick();
      int lo;
      int hi;
      lo = (cfg_dry < cfg_wet) ? cfg_dry : cfg_wet;
      hi = (cfg_dry < cfg_wet) ? cfg_wet : cfg_dry;
      if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 65535)) - 32768;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Bursts of nearly constant samples to build stuck runs, bursts of spread
   // samples to clear the fault, and a share of arbitrary transactions.
   task automatic queue_random_reads(input int count, input int run_cap);
      int   made;
      int   pick;
      int   len;
      int   base;
      int   raw;
      logic ok;
      made = 0;
      while (made < count) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 50) begin
            base = span_pick();
            len = int'($urandom_range(1, int'(cfg_stuck_limit) + 3));
            if (len > run_cap) len = run_cap;
            repeat (len) begin
               raw = base + int'($urandom_range(0, 8)) - 4;
               if (raw > 32767) raw = 32767;
               if (raw < -32768) raw = -32768;
               push_read(SAMPLE_WIDTH'(raw), 1'b1);
               made++;
               if ($urandom_range(0, 15) == 0) push_read(SAMPLE_WIDTH'($urandom), 1'b0);
            end
         end else if (pick < 85) begin
            len = int'($urandom_range(1, int'(cfg_clear_limit) + 2));
            if (len > run_cap) len = run_cap;
            repeat (len) begin
               push_read(SAMPLE_WIDTH'(span_pick()), 1'b1);
               made++;
            end
         end else begin
            ok = 1'($urandom_range(0, 1));
            push_read(SAMPLE_WIDTH'($urandom), ok);
            if (ok) made++;
         end
      end
   endtask

   initial begin
      int span_value;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_read(16'sh1234, 1'b0);
      push_read(-16'sd32768, 1'b1);
      push_read(16'sd32767, 1'b1);
      push_read(16'sd20000, 1'b1);
      push_read(16'sd9000, 1'b1);
      push_read(16'sd14500, 1'b1);
      push_read(16'sd32767, 1'b0);
      repeat (11) push_read(16'sd12000, 1'b1);
      push_read(-16'sd1, 1'b0);
      push_read(16'sd12000, 1'b1);
      push_read(16'sd10000, 1'b1);
      push_read(16'sd16000, 1'b1);
      push_read(16'sd19000, 1'b1);
      queue_random_reads(150, 40);
      wait_drained();

      apply_settings(16'sd32767, -16'sd32768, 16'd25600, 16'd1, 16'd255, 16'd25600);
      queue_random_reads(120, 40);
      wait_drained();

      steady = 1'b1;
      apply_settings(-16'sd32768, 16'sd32767, 16'd0, 16'd255, 16'd1, 16'd0);
      queue_random_reads(120, 40);
      wait_drained();
      steady = 1'b0;

      span_value = int'($urandom_range(0, 65535));
      apply_settings(16'(span_value), 16'(span_value), 16'd1, 16'd4, 16'd2,
                     16'($urandom_range(0, 25600)));
      queue_random_reads(120, 40);
      wait_drained();

      repeat (2) begin
         apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(0, 600)),
                        16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                        16'($urandom_range(0, 25600)));
         queue_random_reads(120, 40);
         wait_drained();
      end

      // Longest limits: a stuck run past counter saturation, then a long recovery.
      apply_settings(16'sd20000, 16'sd9000, 16'd26, 16'd255, 16'd255, 16'd7680);
      repeat (258) push_read(16'sd15000, 1'b1);
      repeat (260) push_read(SAMPLE_WIDTH'(span_pick()), 1'b1);
      queue_random_reads(60, 270);
      wait_drained();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
